>>> rtl/core/sdseq_pkg.sv
// ----------------------------------------------------------------------------
// SD card sequencer package
// Word types, phase codes, command numbers and status codes shared by the
// sequencer step logic and the top level.
// ----------------------------------------------------------------------------
package sdseq_pkg;

    // Event codes carried in the op field of an input word.
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_DONE     = 2'd1;
    localparam logic [1:0] OP_FAIL     = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_CMD0     = 4'd1;
    localparam logic [3:0] PH_CMD8     = 4'd2;
    localparam logic [3:0] PH_A55      = 4'd3;
    localparam logic [3:0] PH_ACMD41   = 4'd4;
    localparam logic [3:0] PH_CMD2     = 4'd5;
    localparam logic [3:0] PH_CMD3     = 4'd6;
    localparam logic [3:0] PH_CMD9     = 4'd7;
    localparam logic [3:0] PH_CMD7     = 4'd8;
    localparam logic [3:0] PH_B55      = 4'd9;
    localparam logic [3:0] PH_ACMD6    = 4'd10;
    localparam logic [3:0] PH_CMD16    = 4'd11;
    localparam logic [3:0] PH_READY    = 4'd12;
    localparam logic [3:0] PH_READ     = 4'd13;

    // Command numbers.
    localparam logic [5:0] CMD_RESET_CARD   = 6'd0;
    localparam logic [5:0] CMD_GET_CID      = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
    localparam logic [5:0] CMD_SET_WIDTH    = 6'd6;
    localparam logic [5:0] CMD_SELECT       = 6'd7;
    localparam logic [5:0] CMD_IF_CHECK     = 6'd8;
    localparam logic [5:0] CMD_GET_CSD      = 6'd9;
    localparam logic [5:0] CMD_BLOCK_SIZE   = 6'd16;
    localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
    localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
    localparam logic [5:0] CMD_SEND_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP_PREFIX   = 6'd55;

    // Response kinds.
    localparam logic [2:0] RK_NONE     = 3'd0;
    localparam logic [2:0] RK_R1       = 3'd1;
    localparam logic [2:0] RK_R1B      = 3'd2;
    localparam logic [2:0] RK_R2       = 3'd3;
    localparam logic [2:0] RK_R3       = 3'd4;

    // Clock requests.
    localparam logic [1:0] CLK_KEEP    = 2'd0;
    localparam logic [1:0] CLK_IDENT   = 2'd1;
    localparam logic [1:0] CLK_DATA    = 2'd2;

    // Final status codes.
    localparam logic [2:0] ST_BUSY_RUN = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_NO_ECHO  = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_FAILED   = 3'd4;
    localparam logic [2:0] ST_REJECTED = 3'd5;

    // Command arguments and response masks.
    localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
    localparam logic [7:0]  IF_COND_ECHO  = 8'hAA;
    localparam logic [31:0] ARG_OP_COND   = 32'h40FF_8000;
    localparam logic [31:0] ARG_WIDTH4    = 32'h0000_0002;
    localparam logic [31:0] ARG_BLOCKLEN  = 32'h0000_0200;
    localparam logic [1:0]  CSD_V2        = 2'b01;

    // Configuration register.
    localparam logic [11:0] RETRY_LIMIT_RESET = 12'd1000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] resp_top;
        logic [31:0] resp_second;
        logic [31:0] resp_third;
        logic [31:0] block_address;
        logic [22:0] block_count;
    } in_word_t;

    typedef struct packed {
        logic        issue;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [2:0]  resp_kind;
        logic [22:0] data_blocks;
        logic        wait_first;
        logic [1:0]  clock_request;
        logic        wide_bus;
        logic [2:0]  status;
        logic        high_capacity;
        logic [15:0] card_address;
        logic [22:0] capacity_units;
    } out_word_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [11:0] retry_count;
        logic [15:0] rel_address;
        logic        hc_flag;
        logic [22:0] capacity;
    } card_state_t;

endpackage

>>> rtl/core/sdseq_step.sv
// ----------------------------------------------------------------------------
// SD card sequencer step logic
// Combinational decision for one event word: the next card state and the
// result word (next command or final status).
// ----------------------------------------------------------------------------
module sdseq_step (
    input  sdseq_pkg::in_word_t    in_data,
    input  sdseq_pkg::card_state_t state,
    input  logic [11:0]            retry_limit,
    output sdseq_pkg::card_state_t state_next,
    output sdseq_pkg::out_word_t   result
);

    logic [31:0] rca_arg;
    logic [11:0] retry_inc;
    logic        init_active;
    logic [21:0] c_size;

    assign rca_arg     = {state.rel_address, 16'h0000};
    assign retry_inc   = state.retry_count + 12'd1;
    assign init_active = (state.phase >= sdseq_pkg::PH_CMD0)
                      && (state.phase <= sdseq_pkg::PH_CMD16);
    assign c_size      = {in_data.resp_second[5:0], in_data.resp_third[31:16]};

    always_comb
    begin
        state_next = state;
        result     = '0;

        unique case (in_data.op)
            sdseq_pkg::OP_START:
            begin
                state_next.rel_address = '0;
                state_next.hc_flag     = 1'b0;
                state_next.capacity    = '0;
                state_next.retry_count = '0;
                state_next.phase       = sdseq_pkg::PH_CMD0;
                result.clock_request   = sdseq_pkg::CLK_IDENT;
                result.issue           = 1'b1;
                result.cmd_index       = sdseq_pkg::CMD_RESET_CARD;
                result.resp_kind       = sdseq_pkg::RK_NONE;
                result.wait_first      = 1'b1;
            end
            sdseq_pkg::OP_FAIL:
            begin
                if (init_active)
                begin
                    result.status    = sdseq_pkg::ST_FAILED;
                    state_next.phase = sdseq_pkg::PH_IDLE;
                end
                else if (state.phase == sdseq_pkg::PH_READ)
                begin
                    result.status    = sdseq_pkg::ST_FAILED;
                    state_next.phase = sdseq_pkg::PH_READY;
                end
                else
                begin
                    result.status = sdseq_pkg::ST_REJECTED;
                end
            end
            sdseq_pkg::OP_READ:
            begin
                if (state.phase == sdseq_pkg::PH_READY && in_data.block_count != '0)
                begin
                    result.issue       = 1'b1;
                    result.cmd_index   = (in_data.block_count == 23'd1)
                                       ? sdseq_pkg::CMD_READ_SINGLE
                                       : sdseq_pkg::CMD_READ_MULTI;
                    // Standard capacity cards take a byte address.
                    result.cmd_arg     = state.hc_flag ? in_data.block_address
                                       : {in_data.block_address[22:0], 9'd0};
                    result.resp_kind   = sdseq_pkg::RK_R1;
                    result.data_blocks = in_data.block_count;
                    state_next.phase   = sdseq_pkg::PH_READ;
                end
                else
                begin
                    result.status = sdseq_pkg::ST_REJECTED;
                end
            end
            default:
            begin
                unique case (state.phase)
                    sdseq_pkg::PH_CMD0:
                    begin
                        result.issue      = 1'b1;
                        result.cmd_index  = sdseq_pkg::CMD_IF_CHECK;
                        result.cmd_arg    = sdseq_pkg::ARG_IF_COND;
                        result.resp_kind  = sdseq_pkg::RK_R1;
                        result.wait_first = 1'b1;
                        state_next.phase  = sdseq_pkg::PH_CMD8;
                    end
                    sdseq_pkg::PH_CMD8:
                    begin
                        if (in_data.resp_top[7:0] != sdseq_pkg::IF_COND_ECHO)
                        begin
                            result.status    = sdseq_pkg::ST_NO_ECHO;
                            state_next.phase = sdseq_pkg::PH_IDLE;
                        end
                        else
                        begin
                            state_next.retry_count = '0;
                            result.issue     = 1'b1;
                            result.cmd_index = sdseq_pkg::CMD_APP_PREFIX;
                            result.cmd_arg   = rca_arg;
                            result.resp_kind = sdseq_pkg::RK_R1;
                            state_next.phase = sdseq_pkg::PH_A55;
                        end
                    end
                    sdseq_pkg::PH_A55:
                    begin
                        result.issue     = 1'b1;
                        result.cmd_index = sdseq_pkg::CMD_SEND_OP_COND;
                        result.cmd_arg   = sdseq_pkg::ARG_OP_COND;
                        result.resp_kind = sdseq_pkg::RK_R3;
                        state_next.phase = sdseq_pkg::PH_ACMD41;
                    end
                    sdseq_pkg::PH_ACMD41:
                    begin
                        state_next.retry_count = retry_inc;
                        // Bit 31 of the OCR set means power-up has finished.
                        if (in_data.resp_top[31])
                        begin
                            state_next.hc_flag = in_data.resp_top[30];
                            result.issue       = 1'b1;
                            result.cmd_index   = sdseq_pkg::CMD_GET_CID;
                            result.resp_kind   = sdseq_pkg::RK_R2;
                            state_next.phase   = sdseq_pkg::PH_CMD2;
                        end
                        else if (retry_inc >= retry_limit)
                        begin
                            result.status    = sdseq_pkg::ST_TIMEOUT;
                            state_next.phase = sdseq_pkg::PH_IDLE;
                        end
                        else
                        begin
                            result.issue      = 1'b1;
                            result.cmd_index  = sdseq_pkg::CMD_APP_PREFIX;
                            result.cmd_arg    = rca_arg;
                            result.resp_kind  = sdseq_pkg::RK_R1;
                            result.wait_first = 1'b1;
                            state_next.phase  = sdseq_pkg::PH_A55;
                        end
                    end
                    sdseq_pkg::PH_CMD2:
                    begin
                        result.issue     = 1'b1;
                        result.cmd_index = sdseq_pkg::CMD_SEND_RCA;
                        result.resp_kind = sdseq_pkg::RK_R1;
                        state_next.phase = sdseq_pkg::PH_CMD3;
                    end
                    sdseq_pkg::PH_CMD3:
                    begin
                        state_next.rel_address = in_data.resp_top[31:16];
                        result.issue     = 1'b1;
                        result.cmd_index = sdseq_pkg::CMD_GET_CSD;
                        result.cmd_arg   = {in_data.resp_top[31:16], 16'h0000};
                        result.resp_kind = sdseq_pkg::RK_R2;
                        state_next.phase = sdseq_pkg::PH_CMD9;
                    end
                    sdseq_pkg::PH_CMD9:
                    begin
                        if (in_data.resp_top[31:30] == sdseq_pkg::CSD_V2)
                        begin
                            state_next.capacity = {1'b0, c_size} + 23'd1;
                        end
                        else
                        begin
                            state_next.capacity = '0;
                        end
                        result.issue     = 1'b1;
                        result.cmd_index = sdseq_pkg::CMD_SELECT;
                        result.cmd_arg   = rca_arg;
                        result.resp_kind = sdseq_pkg::RK_R1B;
                        state_next.phase = sdseq_pkg::PH_CMD7;
                    end
                    sdseq_pkg::PH_CMD7:
                    begin
                        result.issue     = 1'b1;
                        result.cmd_index = sdseq_pkg::CMD_APP_PREFIX;
                        result.cmd_arg   = rca_arg;
                        result.resp_kind = sdseq_pkg::RK_R1;
                        state_next.phase = sdseq_pkg::PH_B55;
                    end
                    sdseq_pkg::PH_B55:
                    begin
                        result.issue     = 1'b1;
                        result.cmd_index = sdseq_pkg::CMD_SET_WIDTH;
                        result.cmd_arg   = sdseq_pkg::ARG_WIDTH4;
                        result.resp_kind = sdseq_pkg::RK_R1;
                        state_next.phase = sdseq_pkg::PH_ACMD6;
                    end
                    sdseq_pkg::PH_ACMD6:
                    begin
                        result.issue     = 1'b1;
                        result.cmd_index = sdseq_pkg::CMD_BLOCK_SIZE;
                        result.cmd_arg   = sdseq_pkg::ARG_BLOCKLEN;
                        result.resp_kind = sdseq_pkg::RK_R1;
                        state_next.phase = sdseq_pkg::PH_CMD16;
                    end
                    sdseq_pkg::PH_CMD16:
                    begin
                        result.clock_request = sdseq_pkg::CLK_DATA;
                        result.status        = sdseq_pkg::ST_READY;
                        state_next.phase     = sdseq_pkg::PH_READY;
                    end
                    sdseq_pkg::PH_READ:
                    begin
                        result.status    = sdseq_pkg::ST_READY;
                        state_next.phase = sdseq_pkg::PH_READY;
                    end
                    default:
                    begin
                        result.status = sdseq_pkg::ST_REJECTED;
                    end
                endcase
            end
        endcase

        result.wide_bus       = (state_next.phase >= sdseq_pkg::PH_CMD16)
                             && (state_next.phase <= sdseq_pkg::PH_READ);
        result.high_capacity  = state_next.hc_flag;
        result.card_address   = state_next.rel_address;
        result.capacity_units = state_next.capacity;
    end

endmodule

>>> rtl/core/sd_card_init_and_read_sequencer_unit.sv
// ----------------------------------------------------------------------------
// SD card initialization and read sequencer
// Command-level sequencer: turns card events into the next command to send.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one event word:
//   start, command completed with its response, command failed, or read
//   request. For every accepted word exactly one result word appears on the
//   output channel (out_valid, out_stall, out_data): the next command to
//   send, or a final status with the captured card details.
//   The card state is updated at the edge that accepts the event; the result
//   word is registered in the output register, or in the skid register if
//   the output word is held. One word per cycle is sustained while the
//   receiver does not stall; the state-to-output decision path is the limit.
//   When the receiver stalls, one further word is taken into a skid register
//   and in_stall then rises until the output register drains.
//   Reset puts the sequencer in the idle phase, clears the card details and
//   sets the busy retry limit to 1000. The user writes the limit over the APB
//   port at byte address 0 while the sequencer is idle; this is not enforced.
// ----------------------------------------------------------------------------
module sd_card_init_and_read_sequencer_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sdseq_pkg::in_word_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sdseq_pkg::out_word_t  out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    sdseq_pkg::card_state_t state_reg;
    sdseq_pkg::card_state_t state_next;
    sdseq_pkg::out_word_t   result;
    sdseq_pkg::out_word_t   out_reg;
    sdseq_pkg::out_word_t   skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic [11:0]            retry_limit_reg;
    logic                   in_fire;
    logic                   out_free;
    logic                   cfg_write;

    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && !paddr[2];

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? 32'd0 : {20'd0, retry_limit_reg};

    sdseq_step u_step (
        .in_data     (in_data),
        .state       (state_reg),
        .retry_limit (retry_limit_reg),
        .state_next  (state_next),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            retry_limit_reg <= sdseq_pkg::RETRY_LIMIT_RESET;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            if (cfg_write)
            begin
                retry_limit_reg <= pwdata[11:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    // The skid register only fills behind a held output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && in_fire) |=> skid_valid_reg)
        else $error("event accepted under stall was not kept");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.op == sdseq_pkg::OP_START) |=>
            (state_reg.phase == sdseq_pkg::PH_CMD0 && state_reg.rel_address == '0))
        else $error("start did not restart the sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != sdseq_pkg::ST_BUSY_RUN) |-> !out_reg.issue)
        else $error("final status word also issues a command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.issue) |->
            (out_reg.cmd_index == '0 && out_reg.cmd_arg == '0 && out_reg.data_blocks == '0))
        else $error("command fields not cleared in a status word");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card sequencer testbench
// Drives start, completion, failure and read events into the sequencer and
// predicts every command and status word in a scoreboard that keeps its own
// copy of the card state. Results are compared field by field. The busy retry
// limit is changed over APB between runs, and random input gaps and output
// stalls are switched on or off from run to run.
// ----------------------------------------------------------------------------

class sd_command_scoreboard;
    sdseq_pkg::out_word_t expected_cmds[$];
    logic [3:0]  phase;
    logic [11:0] retry_count;
    logic [11:0] retry_limit;
    logic [15:0] rca;
    logic        hc;
    logic [22:0] capacity;
    int          errors;
    int          checked;
    int          ready_count;
    int          timeout_count;

    function new();
        phase = sdseq_pkg::PH_IDLE;
        retry_count = '0;
        retry_limit = sdseq_pkg::RETRY_LIMIT_RESET;
        rca = '0;
        hc = 1'b0;
        capacity = '0;
        errors = 0;
        checked = 0;
        ready_count = 0;
        timeout_count = 0;
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction

    function sdseq_pkg::out_word_t command(logic [5:0] idx, logic [31:0] arg,
                                           logic [2:0] kind, logic [22:0] blocks,
                                           logic wait_ms);
        sdseq_pkg::out_word_t w;
        w = '0;
        w.issue = 1'b1;
        w.cmd_index = idx;
        w.cmd_arg = arg;
        w.resp_kind = kind;
        w.data_blocks = blocks;
        w.wait_first = wait_ms;
        return w;
    endfunction

    // Next command or final status after the outstanding one completed.
    function sdseq_pkg::out_word_t advance(sdseq_pkg::in_word_t ev);
        sdseq_pkg::out_word_t r;
        r = '0;
        case (phase)
            sdseq_pkg::PH_CMD0:
            begin
                r = command(sdseq_pkg::CMD_IF_CHECK, sdseq_pkg::ARG_IF_COND,
                            sdseq_pkg::RK_R1, 23'd0, 1'b1);
                phase = sdseq_pkg::PH_CMD8;
            end
            sdseq_pkg::PH_CMD8:
            begin
                if (ev.resp_top[7:0] != sdseq_pkg::IF_COND_ECHO)
                begin
                    r.status = sdseq_pkg::ST_NO_ECHO;
                    phase = sdseq_pkg::PH_IDLE;
                end
                else
                begin
                    retry_count = '0;
                    r = command(sdseq_pkg::CMD_APP_PREFIX, {rca, 16'h0},
                                sdseq_pkg::RK_R1, 23'd0, 1'b0);
                    phase = sdseq_pkg::PH_A55;
                end
            end
            sdseq_pkg::PH_A55:
            begin
                r = command(sdseq_pkg::CMD_SEND_OP_COND, sdseq_pkg::ARG_OP_COND,
                            sdseq_pkg::RK_R3, 23'd0, 1'b0);
                phase = sdseq_pkg::PH_ACMD41;
            end
            sdseq_pkg::PH_ACMD41:
            begin
                retry_count = retry_count + 12'd1;
                // Bit 31 of the OCR set means power-up has finished.
                if (ev.resp_top[31])
                begin
                    hc = ev.resp_top[30];
                    r = command(sdseq_pkg::CMD_GET_CID, 32'h0, sdseq_pkg::RK_R2,
                                23'd0, 1'b0);
                    phase = sdseq_pkg::PH_CMD2;
                end
                else if (retry_count >= retry_limit)
                begin
                    r.status = sdseq_pkg::ST_TIMEOUT;
                    phase = sdseq_pkg::PH_IDLE;
                end
                else
                begin
                    r = command(sdseq_pkg::CMD_APP_PREFIX, {rca, 16'h0},
                                sdseq_pkg::RK_R1, 23'd0, 1'b1);
                    phase = sdseq_pkg::PH_A55;
                end
            end
            sdseq_pkg::PH_CMD2:
            begin
                r = command(sdseq_pkg::CMD_SEND_RCA, 32'h0, sdseq_pkg::RK_R1,
                            23'd0, 1'b0);
                phase = sdseq_pkg::PH_CMD3;
            end
            sdseq_pkg::PH_CMD3:
            begin
                rca = ev.resp_top[31:16];
                r = command(sdseq_pkg::CMD_GET_CSD, {rca, 16'h0}, sdseq_pkg::RK_R2,
                            23'd0, 1'b0);
                phase = sdseq_pkg::PH_CMD9;
            end
            sdseq_pkg::PH_CMD9:
            begin
                // Only a version 2 CSD carries the 22-bit C_SIZE field.
                if (ev.resp_top[31:30] == sdseq_pkg::CSD_V2)
                    capacity = {1'b0, ev.resp_second[5:0], ev.resp_third[31:16]}
                             + 23'd1;
                else
                    capacity = '0;
                r = command(sdseq_pkg::CMD_SELECT, {rca, 16'h0}, sdseq_pkg::RK_R1B,
                            23'd0, 1'b0);
                phase = sdseq_pkg::PH_CMD7;
            end
            sdseq_pkg::PH_CMD7:
            begin
                r = command(sdseq_pkg::CMD_APP_PREFIX, {rca, 16'h0},
                            sdseq_pkg::RK_R1, 23'd0, 1'b0);
                phase = sdseq_pkg::PH_B55;
            end
            sdseq_pkg::PH_B55:
            begin
                r = command(sdseq_pkg::CMD_SET_WIDTH, sdseq_pkg::ARG_WIDTH4,
                            sdseq_pkg::RK_R1, 23'd0, 1'b0);
                phase = sdseq_pkg::PH_ACMD6;
            end
            sdseq_pkg::PH_ACMD6:
            begin
                r = command(sdseq_pkg::CMD_BLOCK_SIZE, sdseq_pkg::ARG_BLOCKLEN,
                            sdseq_pkg::RK_R1, 23'd0, 1'b0);
                phase = sdseq_pkg::PH_CMD16;
            end
            sdseq_pkg::PH_CMD16:
            begin
                r.clock_request = sdseq_pkg::CLK_DATA;
                r.status = sdseq_pkg::ST_READY;
                phase = sdseq_pkg::PH_READY;
            end
            sdseq_pkg::PH_READ:
            begin
                r.status = sdseq_pkg::ST_READY;
                phase = sdseq_pkg::PH_READY;
            end
            default:
                r.status = sdseq_pkg::ST_REJECTED;
        endcase
        return r;
    endfunction

    function void note_event(sdseq_pkg::in_word_t ev);
        sdseq_pkg::out_word_t r;
        logic                 active;
        r = '0;
        active = (phase >= sdseq_pkg::PH_CMD0) && (phase <= sdseq_pkg::PH_CMD16);
        case (ev.op)
            sdseq_pkg::OP_START:
            begin
                rca = '0;
                hc = 1'b0;
                capacity = '0;
                retry_count = '0;
                r = command(sdseq_pkg::CMD_RESET_CARD, 32'h0, sdseq_pkg::RK_NONE,
                            23'd0, 1'b1);
                r.clock_request = sdseq_pkg::CLK_IDENT;
                phase = sdseq_pkg::PH_CMD0;
            end
            sdseq_pkg::OP_FAIL:
            begin
                if (active)
                begin
                    r.status = sdseq_pkg::ST_FAILED;
                    phase = sdseq_pkg::PH_IDLE;
                end
                else if (phase == sdseq_pkg::PH_READ)
                begin
                    r.status = sdseq_pkg::ST_FAILED;
                    phase = sdseq_pkg::PH_READY;
                end
                else
                    r.status = sdseq_pkg::ST_REJECTED;
            end
            sdseq_pkg::OP_READ:
            begin
                if (phase == sdseq_pkg::PH_READY && ev.block_count != 23'd0)
                begin
                    // Standard-capacity cards take a byte address, which wraps.
                    r = command((ev.block_count == 23'd1) ? sdseq_pkg::CMD_READ_SINGLE
                                                          : sdseq_pkg::CMD_READ_MULTI,
                                hc ? ev.block_address : {ev.block_address[22:0], 9'd0},
                                sdseq_pkg::RK_R1, ev.block_count, 1'b0);
                    phase = sdseq_pkg::PH_READ;
                end
                else
                    r.status = sdseq_pkg::ST_REJECTED;
            end
            sdseq_pkg::OP_DONE:
                r = advance(ev);
        endcase
        r.wide_bus = (phase >= sdseq_pkg::PH_CMD16) && (phase <= sdseq_pkg::PH_READ);
        r.high_capacity = hc;
        r.card_address = rca;
        r.capacity_units = capacity;
        expected_cmds.push_back(r);
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d field %s: got %0h, expected %0h",
                                      checked, name, got, want));
    endtask

    task check_command(sdseq_pkg::out_word_t got);
        sdseq_pkg::out_word_t want;
        if (expected_cmds.size() == 0)
        begin
            report_mismatch($sformatf("result word %h with no event pending", got));
            return;
        end
        want = expected_cmds.pop_front();
        checked++;
        if (want.clock_request == sdseq_pkg::CLK_DATA)
            ready_count++;
        if (want.status == sdseq_pkg::ST_TIMEOUT)
            timeout_count++;
        compare_field("issue", 32'(got.issue), 32'(want.issue));
        compare_field("cmd_index", 32'(got.cmd_index), 32'(want.cmd_index));
        compare_field("cmd_arg", got.cmd_arg, want.cmd_arg);
        compare_field("resp_kind", 32'(got.resp_kind), 32'(want.resp_kind));
        compare_field("data_blocks", 32'(got.data_blocks), 32'(want.data_blocks));
        compare_field("wait_first", 32'(got.wait_first), 32'(want.wait_first));
        compare_field("clock_request", 32'(got.clock_request),
                      32'(want.clock_request));
        compare_field("wide_bus", 32'(got.wide_bus), 32'(want.wide_bus));
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("high_capacity", 32'(got.high_capacity),
                      32'(want.high_capacity));
        compare_field("card_address", 32'(got.card_address), 32'(want.card_address));
        compare_field("capacity_units", 32'(got.capacity_units),
                      32'(want.capacity_units));
    endtask
endclass

module tb;
    localparam int         HALF_PERIOD      = 10;
    localparam int         TARGET_EVENTS    = 1300;
    localparam int         EVENTS_PER_LIMIT = 160;
    localparam logic [2:0] ADDR_RETRY_LIMIT = 3'd0;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    sdseq_pkg::in_word_t  in_data;
    logic                 out_valid;
    logic                 out_stall;
    sdseq_pkg::out_word_t out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    sd_command_scoreboard sb;
    int          events_sent;
    int          sessions;
    int          settings_used;
    int          in_gap_max;
    int          out_stall_max;
    int          stall_left;
    logic [11:0] cur_limit;

    sd_card_init_and_read_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Accepted events feed the prediction before the result words are checked,
    // since a result can never leave in the cycle its event is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_event(in_data);
            if (out_valid && !out_stall)
            begin
                sb.check_command(out_data);
                stall_left = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [22:0] rand_count();
        case ($urandom_range(0, 7))
            0: return 23'd0;
            1, 2, 3: return 23'd1;
            4, 5: return 23'($urandom_range(2, 16));
            6: return 23'($urandom_range(0, 32'h007F_FFFF));
            default: return 23'h7F_FFFF;
        endcase
    endfunction

    task automatic send_event(logic [1:0] op, logic [31:0] top, logic [31:0] second,
                              logic [31:0] third, logic [31:0] addr, logic [22:0] count);
        int                  gap;
        sdseq_pkg::in_word_t ev;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        ev.op = op;
        ev.resp_top = top;
        ev.resp_second = second;
        ev.resp_third = third;
        ev.block_address = addr;
        ev.block_count = count;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= ev;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        events_sent++;
    endtask

    // Now and then an unrelated word is slipped in ahead of the intended one.
    task automatic feed(logic [1:0] op, logic [31:0] top, logic [31:0] second,
                        logic [31:0] third, logic [31:0] addr, logic [22:0] count);
        if ($urandom_range(0, 29) == 0)
            send_event(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_count());
        send_event(op, top, second, third, addr, count);
    endtask

    task automatic feed_done(logic [31:0] top);
        feed(sdseq_pkg::OP_DONE, top, rand_word(), rand_word(), rand_word(),
             rand_count());
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_RETRY_LIMIT;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_retry_limit();
        logic [31:0] readback;
        apb_access(1'b0, 32'h0, readback);
        if (readback !== {20'd0, cur_limit})
            sb.report_mismatch($sformatf("retry limit reads %0h, expected %0h",
                                         readback, cur_limit));
    endtask

    // A card bring-up with random responses; 1 to 8 reads if it gets ready.
    task automatic card_session();
        int          lim;
        int          busy_polls;
        int          k;
        logic [31:0] w;
        logic [22:0] count;
        lim = (cur_limit == 12'd0) ? 1 : int'(cur_limit);
        sessions++;
        feed(sdseq_pkg::OP_START, rand_word(), rand_word(), rand_word(), rand_word(),
             rand_count());
        feed_done(rand_word());
        w = rand_word();
        if ($urandom_range(0, 9) == 0)
        begin
            w[7:0] = 8'($urandom_range(0, 255));
            if (w[7:0] == sdseq_pkg::IF_COND_ECHO)
                w[7:0] = 8'h2A;
            feed_done(w);
            return;
        end
        w[7:0] = sdseq_pkg::IF_COND_ECHO;
        feed_done(w);
        busy_polls = $urandom_range(0, (lim < 6) ? lim : 6);
        for (k = 0; k < busy_polls; k++)
        begin
            feed_done(rand_word());
            w = rand_word();
            w[31] = 1'b0;
            feed_done(w);
            if (k + 1 >= lim)
                return;
        end
        feed_done(rand_word());
        w = rand_word();
        w[31] = 1'b1;
        feed_done(w);
        feed_done(rand_word());
        feed_done(rand_word());
        w = rand_word();
        if ($urandom_range(0, 3) != 0)
            w[31:30] = sdseq_pkg::CSD_V2;
        feed_done(w);
        repeat (4) feed_done(rand_word());
        repeat ($urandom_range(1, 8))
        begin
            count = rand_count();
            feed(sdseq_pkg::OP_READ, rand_word(), rand_word(), rand_word(), rand_word(),
                 count);
            if (count != 23'd0)
            begin
                if ($urandom_range(0, 9) == 0)
                    feed(sdseq_pkg::OP_READ, rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_count());
                if ($urandom_range(0, 7) == 0)
                    feed(sdseq_pkg::OP_FAIL, rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_count());
                else
                    feed_done(rand_word());
            end
        end
        if ($urandom_range(0, 4) == 0)
            feed($urandom_range(0, 1) ? sdseq_pkg::OP_DONE : sdseq_pkg::OP_FAIL,
                 rand_word(), rand_word(), rand_word(), rand_word(), rand_count());
    endtask

    initial
    begin
        int          k;
        int          mode;
        int          phase_start;
        int          guard;
        logic [31:0] limit_word;
        logic [31:0] readback;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_gap_max = 11;
        out_stall_max = 11;
        stall_left = 0;
        cur_limit = sdseq_pkg::RETRY_LIMIT_RESET;
        events_sent = 0;
        sessions = 0;
        settings_used = 1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        check_retry_limit();

        // Rejections while idle, an init failure, a missing CMD8 echo.
        send_event(sdseq_pkg::OP_DONE, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_FAIL, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_READ, '1, '1, '1, 32'hFFFF_FFFF, 23'h7F_FFFF);
        send_event(sdseq_pkg::OP_START, '1, '1, '1, '1, '1);
        send_event(sdseq_pkg::OP_FAIL, '1, '1, '1, '1, '1);
        send_event(sdseq_pkg::OP_START, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, 32'h0000_0155, 32'h0, 32'h0, 32'h0, 23'd0);
        // Full bring-up of a high-capacity card with the largest CSD size.
        send_event(sdseq_pkg::OP_START, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, '1, '1, '1, '1, '1);
        send_event(sdseq_pkg::OP_DONE, 32'hFFFF_FFAA, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, '1, '1, '1, '1, '1);
        send_event(sdseq_pkg::OP_DONE, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_DONE, 32'h4000_0000, 32'h0000_003F, 32'hFFFF_0000,
                   32'h0, 23'd0);
        repeat (4) send_event(sdseq_pkg::OP_DONE, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        // Zero-length read, single and multiple block reads, overlap, failure.
        send_event(sdseq_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 23'd0);
        send_event(sdseq_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 23'd1);
        send_event(sdseq_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, 23'd2);
        send_event(sdseq_pkg::OP_DONE, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);
        send_event(sdseq_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, 23'h7F_FFFF);
        send_event(sdseq_pkg::OP_FAIL, 32'h0, 32'h0, 32'h0, 32'h0, 23'd0);

        k = 0;
        while (events_sent < TARGET_EVENTS)
        begin
            k++;
            wait_drained();
            case (k)
                1: limit_word = 32'd1;
                2: limit_word = 32'hFFFF_FFFF;
                3: limit_word = 32'd0;
                4: limit_word = 32'd2;
                5: limit_word = 32'd3;
                default: limit_word = ($urandom_range(0, 3) == 0) ?
                                      $urandom_range(1, 4095) : $urandom_range(1, 6);
            endcase
            apb_access(1'b1, limit_word, readback);
            cur_limit = limit_word[11:0];
            sb.retry_limit = limit_word[11:0];
            settings_used++;
            check_retry_limit();
            mode = k % 4;
            in_gap_max = (mode == 1 || mode == 3) ? 0 : 11;
            out_stall_max = (mode == 2 || mode == 3) ? 0 : 11;
            phase_start = events_sent;
            while (events_sent - phase_start < EVENTS_PER_LIMIT)
            begin
                card_session();
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
            end
        end

        in_valid <= 1'b0;
        for (guard = 0; guard < 2000 && sb.pending() != 0; guard++)
            @(negedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d result words never arrived", sb.pending()));
        repeat (4) @(negedge clk);

        $display("summary: %0d events over %0d card sessions and %0d retry limit settings",
                 events_sent, sessions, settings_used);
        $display("summary: %0d result words checked, %0d bring-ups reached ready, %0d %s",
                 sb.checked, sb.ready_count, sb.timeout_count, "busy timeouts");
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("status: fail");
        $finish;
    end
endmodule
